### design/ili_pkg.sv
// shared types and constants for the indexed list insert block
package ili_pkg;

   localparam int DEPTH_DEFAULT       = 32;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int POS_WIDTH           = 10;
   localparam int ELEM_WIDTH          = 32;

   typedef enum logic [1:0] {
      KIND_FORWARD = 2'd0,
      KIND_REVERSE = 2'd1,
      KIND_INVALID = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FORWARD,
      ST_REVERSE
   } state_type;

   typedef struct packed {
      logic     capture;
      logic     insert;
      logic     idx_clear;
      logic     idx_inc;
      logic     idx_dec;
      logic     load;
      kind_type kind;
      logic     last;
   } cmd_type;

   typedef struct packed {
      logic pos_invalid;
      logic full;
      logic idx_last;
      logic idx_zero;
      logic slot_free;
   } status_type;

endpackage

### design/ili_ctrl.sv
// controller state machine for the indexed list insert block
module ili_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ili_pkg::status_type status,
   output ili_pkg::cmd_type    cmd
);
   import ili_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.pos_invalid || status.full) begin
               if (status.slot_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_FORWARD;
            end
         end
         ST_FORWARD: begin
            if (status.slot_free && status.idx_last) begin
               state_in = ST_REVERSE;
            end
         end
         ST_REVERSE: begin
            if (status.slot_free && status.idx_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.kind      = KIND_FORWARD;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECIDE: begin
            if (status.pos_invalid) begin
               cmd.load = status.slot_free;
               cmd.kind = KIND_INVALID;
               cmd.last = 1'b1;
            end else if (status.full) begin
               cmd.load = status.slot_free;
               cmd.kind = KIND_FULL;
               cmd.last = 1'b1;
            end else begin
               cmd.insert    = 1'b1;
               cmd.idx_clear = 1'b1;
            end
         end
         ST_FORWARD: begin
            cmd.load    = status.slot_free;
            cmd.kind    = KIND_FORWARD;
            cmd.idx_inc = status.slot_free && !status.idx_last;
         end
         ST_REVERSE: begin
            cmd.load    = status.slot_free;
            cmd.kind    = KIND_REVERSE;
            cmd.last    = status.idx_zero;
            cmd.idx_dec = status.slot_free && !status.idx_zero;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### design/ili_dpath.sv
// list storage, count, walk index and output register
module ili_dpath #(
   parameter int DEPTH       = ili_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = ili_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ili_pkg::POS_WIDTH-1:0]        req_position,
   input  logic signed [ili_pkg::ELEM_WIDTH-1:0] req_value,
   input  ili_pkg::cmd_type                     cmd,
   output ili_pkg::status_type                  status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_kind,
   output logic signed [ili_pkg::ELEM_WIDTH-1:0] rsp_element,
   output logic                                 rsp_last
);
   import ili_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [POS_WIDTH-1:0]          pos_ff;
   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [IDX_W-1:0]              idx_ff;
   logic [IDX_W-1:0]              idx_in;
   logic signed [VALUE_WIDTH-1:0] entries_ff [DEPTH];
   logic signed [VALUE_WIDTH-1:0] entries_in [DEPTH];
   logic signed [VALUE_WIDTH-1:0] read_value;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   kind_type                      kind_ff;
   logic signed [ELEM_WIDTH-1:0]  element_ff;
   logic signed [ELEM_WIDTH-1:0]  element_in;
   logic                          last_ff;

   // captured word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff <= req_position;
         val_ff <= VALUE_WIDTH'(req_value);
      end
   end

   // shift up and insert in one step
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      if (i == 0) begin : g_head
         always_comb begin
            entries_in[i] = entries_ff[i];
            if (cmd.insert && (pos_ff == POS_WIDTH'(i))) begin
               entries_in[i] = val_ff;
            end
         end
      end else begin : g_body
         always_comb begin
            entries_in[i] = entries_ff[i];
            if (cmd.insert) begin
               if (pos_ff == POS_WIDTH'(i)) begin
                  entries_in[i] = val_ff;
               end else if ((pos_ff < POS_WIDTH'(i)) && (CNT_W'(i) <= count_ff)) begin
                  entries_in[i] = entries_ff[i-1];
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   assign count_in = cmd.insert ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
   end

   assign read_value = entries_ff[idx_ff];

   assign status.pos_invalid = pos_ff > POS_WIDTH'(count_ff);
   assign status.full        = count_ff == CNT_W'(DEPTH);
   assign status.idx_last    = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign status.idx_zero    = idx_ff == '0;
   assign status.slot_free   = !rsp_valid_ff || rsp_ready;

   // output word register
   assign rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);
   assign element_in   = ((cmd.kind == KIND_FORWARD) || (cmd.kind == KIND_REVERSE))
                         ? ELEM_WIDTH'(read_value) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         kind_ff    <= cmd.kind;
         element_ff <= element_in;
         last_ff    <= cmd.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_element = element_ff;
   assign rsp_last    = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count above depth");

   a_insert_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (!status.pos_invalid && !status.full))
      else $error("insert on invalid index or full list");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list by one");

   a_load_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load)
      else $error("output word overwritten while stalled");
`endif

endmodule

### design/indexed_list_insert.sv
// top level of the indexed list insert block
//
// Keeps an ordered list of up to DEPTH signed values. Each request word gives
// a position and a value; a position at most the count inserts the value
// there, and the block answers with the whole list front to back (kind 0),
// then back to front (kind 1), last set on the final word. A position above
// the count answers one kind 2 word, a full list one kind 3 word, element zero.
// An insert is taken in the idle state, checked and shifted in parallel in
// the decide state, then answered with one response word per cycle while
// the output register is free (rsp_ready low stalls it), out of a single
// read mux into the output register. A rejected request gets its one word
// from the decide state. A new request is taken as soon as the controller
// is idle, even while the last response word still waits.
module indexed_list_insert #(
   parameter int DEPTH       = ili_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = ili_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ili_pkg::POS_WIDTH-1:0]         req_position,
   input  logic signed [ili_pkg::ELEM_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_kind,
   output logic signed [ili_pkg::ELEM_WIDTH-1:0] rsp_element,
   output logic                                  rsp_last
);
   import ili_pkg::*;

   cmd_type    cmd;
   status_type status;

   ili_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ili_dpath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_position (req_position),
      .req_value    (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last)
   );

endmodule

### test/list_checker.sv
// checker for the indexed list insert block: predicts the list and compares response words
`timescale 1ns / 1ps

module list_checker #(
   parameter int DEPTH = ili_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [ili_pkg::POS_WIDTH-1:0]         req_position,
   input  logic signed [ili_pkg::ELEM_WIDTH-1:0] req_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [1:0]                            rsp_kind,
   input  logic signed [ili_pkg::ELEM_WIDTH-1:0] rsp_element,
   input  logic                                  rsp_last,
   output int                                    errors,
   output int                                    pending
);
   import ili_pkg::*;

   typedef struct packed {
      kind_type                     kind;
      logic signed [ELEM_WIDTH-1:0] element;
      logic                         last;
   } list_word_type;

   list_word_type                expected_words[$];
   logic signed [ELEM_WIDTH-1:0] list_entries[DEPTH];
   int                           list_count = 0;
   int                           mismatch_count = 0;

   assign errors = mismatch_count;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic push_word(input kind_type kind, input logic signed [ELEM_WIDTH-1:0] element,
                            input logic last);
      list_word_type w;
      w.kind    = kind;
      w.element = element;
      w.last    = last;
      expected_words.push_back(w);
   endtask

   task automatic insert_and_list(input logic [POS_WIDTH-1:0] position,
                                  input logic signed [ELEM_WIDTH-1:0] value);
      int p;
      p = int'(position);
      if (p > list_count) begin
         push_word(KIND_INVALID, '0, 1'b1);
      end else if (list_count >= DEPTH) begin
         push_word(KIND_FULL, '0, 1'b1);
      end else begin
         for (int i = list_count; i > p; i--) list_entries[i] = list_entries[i-1];
         list_entries[p] = value;
         list_count++;
         for (int i = 0; i < list_count; i++) push_word(KIND_FORWARD, list_entries[i], 1'b0);
         for (int i = list_count - 1; i >= 0; i--)
            push_word(KIND_REVERSE, list_entries[i], i == 0);
      end
   endtask

   always @(posedge clock) begin
      list_word_type want;
      if (reset) begin
         expected_words.delete();
         list_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word kind %0d element %0d last %0b",
                                         rsp_kind, rsp_element, rsp_last));
            end else begin
               want = expected_words.pop_front();
               if (rsp_kind !== want.kind || rsp_element !== want.element ||
                   rsp_last !== want.last)
                  report_mismatch($sformatf(
                     "got kind %0d element %0d last %0b, want kind %0d element %0d last %0b",
                     rsp_kind, rsp_element, rsp_last, want.kind, want.element, want.last));
            end
         end
         if (req_valid && req_ready) insert_and_list(req_position, req_value);
      end
      pending <= expected_words.size();
   end

endmodule

### test/testbench.sv
// testbench top for the indexed list insert block: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module testbench;
   import ili_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam int HOLD_START = 2500;
   localparam int HOLD_LEN   = 600;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic [POS_WIDTH-1:0]         req_position = '0;
   logic signed [ELEM_WIDTH-1:0] req_value = '0;
   logic                         rsp_ready = 1'b0;
   wire                          req_ready;
   wire                          rsp_valid;
   wire  [1:0]                   rsp_kind;
   wire  signed [ELEM_WIDTH-1:0] rsp_element;
   wire                          rsp_last;

   int fail_count;
   int words_pending;
   int list_size = 0;
   int burst_left = 0;
   int rx_cycles = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   always #5 clock = ~clock;

   indexed_list_insert #(
      .DEPTH(LIST_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH_DEFAULT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_element(rsp_element),
      .rsp_last(rsp_last)
   );

   list_checker #(
      .DEPTH(LIST_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_element(rsp_element),
      .rsp_last(rsp_last),
      .errors(fail_count),
      .pending(words_pending)
   );

   // receiver: changing stall patterns plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycles <= rx_cycles + 1;
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(20, 200);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= (rx_cycles % 3 == 0);
               default: rsp_ready <= ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   task automatic offer_word(input int position, input logic [ELEM_WIDTH-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_position <= position[POS_WIDTH-1:0];
      req_value    <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (position <= list_size && list_size < LIST_DEPTH) list_size++;
   endtask

   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   function automatic logic [ELEM_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_position(input logic fits);
      if (fits) begin
         case ($urandom_range(0, 3))
            0: return 0;
            1: return list_size;
            default: return $urandom_range(0, list_size);
         endcase
      end
      if ($urandom_range(0, 1) == 0) return $urandom_range(list_size + 1, list_size + 4);
      return $urandom_range(list_size + 1, 1023);
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list, front, back and middle inserts, positions above the count, value extremes
      offer_word(1, 32'd5);
      offer_word(1023, 32'hffff_ffff);
      offer_word(0, 32'h7fff_ffff);
      offer_word(0, 32'h8000_0000);
      offer_word(2, 32'hffff_ffff);
      offer_word(1, 32'h0);
      offer_word(5, 32'h1234_5678);
      offer_word(4, 32'h5555_5555);
      offer_word(2, 32'haaaa_aaaa);
      offer_word(0, 32'd1);
      offer_word(512, 32'h0);
      offer_word(7, 32'h8000_0001);
      offer_word(0, 32'h7fff_fffe);
      offer_word(9, 32'hdead_beef);
      wait_idle();

      for (int n = 0; n < 240; n++) begin
         if (n == 120) wait_idle();
         if (list_size < LIST_DEPTH)
            offer_word(pick_position($urandom_range(0, 3) != 0), pick_value());
         else if ($urandom_range(0, 1) == 0)
            offer_word($urandom_range(0, LIST_DEPTH), pick_value());
         else
            offer_word(pick_position(1'b0), pick_value());
      end

      // make sure the full list is reached and rejected
      while (list_size < LIST_DEPTH) offer_word(pick_position(1'b1), pick_value());
      offer_word(LIST_DEPTH, pick_value());
      offer_word(0, pick_value());
      offer_word(LIST_DEPTH + 1, pick_value());
      offer_word(1023, pick_value());

      wait_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && words_pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
